// File: src/slr_pkg.sv
// -----------------------------------------------------------------------------
// slr_pkg
// Shared types, widths and codes of the multichannel slew limiter.
// -----------------------------------------------------------------------------
package slr_pkg;

   localparam int NUM_CHANNELS_DEF = 10;

   localparam int KIND_W    = 3;
   localparam int CHAN_W    = 4;
   localparam int SPEED_W   = 8;
   localparam int SLEW_W    = 15;
   localparam int RAMP_W    = 16;
   localparam int FRAC_W    = 8;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET_TARGET   = 3'd0,
      KIND_SET_BYPASS   = 3'd1,
      KIND_SET_SLEW     = 3'd2,
      KIND_ADD_CHANNEL  = 3'd3,
      KIND_ACTIVATE     = 3'd4,
      KIND_DEACTIVATE   = 3'd5,
      KIND_TICK         = 3'd6
   } kind_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MAX = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MIN = 1'd1;

   localparam logic signed [SPEED_W-1:0] SPEED_MAX_RST = 8'sd127;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN_RST = -8'sd127;

   typedef struct packed {
      logic signed [SPEED_W-1:0] target;
      logic signed [RAMP_W-1:0]  ramp;
      logic        [SLEW_W-1:0]  step;
   } entry_type;

   typedef struct packed {
      logic                      differ;
      logic signed [RAMP_W-1:0]  ramp;
      logic signed [SPEED_W-1:0] drive;
   } ramp_result_type;

endpackage

// File: src/multichannel_slew_limiter.sv
// -----------------------------------------------------------------------------
// multichannel_slew_limiter
// Per-channel motor ramp limiter with state held in one channel memory.
// -----------------------------------------------------------------------------
// Requests enter on the req_ channel (valid/stall); the block raises req_stall
// while it works on a request. Commands set a channel's target, target and
// ramp (bypass), slew, add, activate or deactivate it; commands to channels at
// or above NUM_CHANNELS and the unused kind are dropped. Activate and
// deactivate only set or clear the channel's active bit; the other commands
// read, modify and write back the channel entry.
// A tick scans all channels through the memory read port, one channel per
// cycle while the scan is not paused. Each active channel off target
// yields one rsp_ result (channel, drive, last); last marks the final result
// of the tick. One result is held back until the next is found so that last
// is known. The scan pauses while a result waits on a stalled output register.
// Registers speed_max and speed_min are written on the csr_ port, always
// ready. Reset clears all channels to zero and inactive at once.
// -----------------------------------------------------------------------------
module multichannel_slew_limiter
   import slr_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic [CHAN_W-1:0]         req_channel,
   input  logic signed [SPEED_W-1:0] req_speed,
   input  logic [SLEW_W-1:0]         req_slew_rate,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CHAN_W-1:0]         rsp_out_channel,
   output logic signed [SPEED_W-1:0] rsp_drive,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [SPEED_W-1:0]        csr_wdata
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CMD   = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [SPEED_W-1:0] speed_max_ff, speed_min_ff;
   logic [NUM_CHANNELS-1:0]   enabled_ff, enabled_in;
   kind_type                  cmd_kind_ff, cmd_kind_in;
   logic signed [SPEED_W-1:0] cmd_speed_ff, cmd_speed_in;
   logic [SLEW_W-1:0]         cmd_slew_ff, cmd_slew_in;
   logic [IDX_W-1:0]          cmd_idx_ff, cmd_idx_in;
   logic [CNT_W-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                      st2_valid_ff, st2_valid_in;
   logic [IDX_W-1:0]          calc_idx_ff, calc_idx_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [CHAN_W-1:0]         pend_chan_ff, pend_chan_in;
   logic signed [SPEED_W-1:0] pend_drive_ff, pend_drive_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_chan_ff, rsp_chan_in;
   logic signed [SPEED_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_accept;
   logic                      in_range;
   kind_type                  kind;
   logic                      out_free;
   logic                      emit;
   logic                      scan_block;
   logic                      scan_more;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   entry_type                 wr_data;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   entry_type                 rd_data;
   ramp_result_type           ramp_res;

   slr_mem #(
      .DEPTH  (NUM_CHANNELS),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   slr_ramp u_ramp (
      .entry     (rd_data),
      .speed_max (speed_max_ff),
      .speed_min (speed_min_ff),
      .result    (ramp_res)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign kind       = kind_type'(req_kind);
   assign in_range   = (32'(req_channel) < NUM_CHANNELS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = st2_valid_ff && enabled_ff[calc_idx_ff] && ramp_res.differ;
   assign scan_block = emit && pend_valid_ff && !out_free;
   assign scan_more  = (rd_cnt_ff < CNT_W'(NUM_CHANNELS));

   always_comb begin
      state_in      = state_ff;
      enabled_in    = enabled_ff;
      cmd_kind_in   = cmd_kind_ff;
      cmd_speed_in  = cmd_speed_ff;
      cmd_slew_in   = cmd_slew_ff;
      cmd_idx_in    = cmd_idx_ff;
      rd_cnt_in     = rd_cnt_ff;
      st2_valid_in  = st2_valid_ff;
      calc_idx_in   = calc_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_chan_in  = pend_chan_ff;
      pend_drive_in = pend_drive_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_chan_in   = rsp_chan_ff;
      rsp_drive_in  = rsp_drive_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = calc_idx_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = rd_cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_kind_in  = kind;
               cmd_speed_in = req_speed;
               cmd_slew_in  = req_slew_rate;
               cmd_idx_in   = IDX_W'(req_channel);
               if (kind == KIND_TICK) begin
                  state_in     = ST_SCAN;
                  rd_cnt_in    = '0;
                  st2_valid_in = 1'b0;
               end else if (in_range) begin
                  priority if (kind == KIND_ACTIVATE) begin
                     enabled_in[IDX_W'(req_channel)] = 1'b1;
                  end else if (kind == KIND_DEACTIVATE) begin
                     enabled_in[IDX_W'(req_channel)] = 1'b0;
                  end else if (kind == KIND_SET_TARGET || kind == KIND_SET_BYPASS ||
                               kind == KIND_SET_SLEW || kind == KIND_ADD_CHANNEL) begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(req_channel);
                     state_in = ST_CMD;
                     if (kind == KIND_ADD_CHANNEL) begin
                        enabled_in[IDX_W'(req_channel)] = 1'b1;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_CMD: begin
            wr_en   = 1'b1;
            wr_addr = cmd_idx_ff;
            unique case (cmd_kind_ff)
               KIND_SET_TARGET: begin
                  wr_data.target = cmd_speed_ff;
               end
               KIND_SET_BYPASS: begin
                  wr_data.target = cmd_speed_ff;
                  wr_data.ramp   = $signed({cmd_speed_ff, {FRAC_W{1'b0}}});
               end
               KIND_SET_SLEW: begin
                  wr_data.step = cmd_slew_ff;
               end
               KIND_ADD_CHANNEL: begin
                  wr_data.target = '0;
                  wr_data.ramp   = '0;
                  wr_data.step   = cmd_slew_ff;
               end
               default: begin
                  wr_data = rd_data;
               end
            endcase
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (!scan_block) begin
               rd_en        = scan_more;
               st2_valid_in = scan_more;
               calc_idx_in  = rd_cnt_ff[IDX_W-1:0];
               if (scan_more) begin
                  rd_cnt_in = rd_cnt_ff + CNT_W'(1);
               end else begin
                  state_in = ST_FLUSH;
               end
               if (emit) begin
                  wr_en         = 1'b1;
                  wr_data.ramp  = ramp_res.ramp;
                  pend_valid_in = 1'b1;
                  pend_chan_in  = CHAN_W'(calc_idx_ff);
                  pend_drive_in = ramp_res.drive;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_chan_in  = pend_chan_ff;
                     rsp_drive_in = pend_drive_ff;
                     rsp_last_in  = 1'b0;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chan_in   = pend_chan_ff;
               rsp_drive_in  = pend_drive_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enabled_ff    <= '0;
         st2_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         st2_valid_ff  <= st2_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_kind_ff   <= cmd_kind_in;
      cmd_speed_ff  <= cmd_speed_in;
      cmd_slew_ff   <= cmd_slew_in;
      cmd_idx_ff    <= cmd_idx_in;
      calc_idx_ff   <= calc_idx_in;
      pend_chan_ff  <= pend_chan_in;
      pend_drive_ff <= pend_drive_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_max_ff <= SPEED_MAX_RST;
         speed_min_ff <= SPEED_MIN_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_SPEED_MAX) begin
            speed_max_ff <= $signed(csr_wdata);
         end else if (csr_index == CSR_SPEED_MIN) begin
            speed_min_ff <= $signed(csr_wdata);
         end
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_drive       = rsp_drive_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: src/slr_mem.sv
// -----------------------------------------------------------------------------
// slr_mem
// Channel state memory: one write port, one registered read port. Entries
// never written since reset read as zero.
// -----------------------------------------------------------------------------
module slr_mem
   import slr_pkg::*;
#(
   parameter int DEPTH  = NUM_CHANNELS_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type              mem [DEPTH];
   logic      [DEPTH-1:0]  written_ff;
   entry_type              rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/slr_ramp.sv
// -----------------------------------------------------------------------------
// slr_ramp
// One ramp step: move toward target by at most the slew rate, clamp to the
// speed bounds and truncate the Q8.8 value toward zero.
// -----------------------------------------------------------------------------
module slr_ramp
   import slr_pkg::*;
(
   input  entry_type                 entry,
   input  logic signed [SPEED_W-1:0] speed_max,
   input  logic signed [SPEED_W-1:0] speed_min,
   output ramp_result_type           result
);

   logic signed [RAMP_W:0]   v_x;
   logic signed [RAMP_W:0]   req_x;
   logic signed [RAMP_W:0]   step_x;
   logic signed [RAMP_W:0]   up;
   logic signed [RAMP_W:0]   down;
   logic signed [RAMP_W:0]   v2;
   logic signed [RAMP_W-1:0] req;
   logic signed [RAMP_W-1:0] v2n;
   logic signed [RAMP_W-1:0] hi;
   logic signed [RAMP_W-1:0] lo;
   logic signed [RAMP_W-1:0] v3;
   logic signed [RAMP_W-1:0] v4;
   logic                     frac_adj;

   always_comb begin
      req    = $signed({entry.target, {FRAC_W{1'b0}}});
      v_x    = $signed({entry.ramp[RAMP_W-1], entry.ramp});
      req_x  = $signed({req[RAMP_W-1], req});
      step_x = $signed({2'b00, entry.step});
      up     = v_x + step_x;
      down   = v_x - step_x;
      if (req_x > v_x) begin
         v2 = (up > req_x) ? req_x : up;
      end else begin
         v2 = (down < req_x) ? req_x : down;
      end
      v2n = $signed(v2[RAMP_W-1:0]);
      hi  = $signed({speed_max, {FRAC_W{1'b0}}});
      lo  = $signed({speed_min, {FRAC_W{1'b0}}});
      v3  = (v2n > hi) ? hi : v2n;
      v4  = (v3 < lo) ? lo : v3;
      frac_adj = v4[RAMP_W-1] && (v4[FRAC_W-1:0] != '0);
      result.differ = (entry.ramp != req);
      result.ramp   = v4;
      result.drive  = $signed(v4[RAMP_W-1:FRAC_W] + {{(SPEED_W-1){1'b0}}, frac_adj});
   end

endmodule

// File: src/slr_checker.sv
// -----------------------------------------------------------------------------
// slr_checker
// Port-level assertions for the multichannel slew limiter, bound to the top.
// -----------------------------------------------------------------------------
module slr_checker
   import slr_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [KIND_W-1:0]         req_kind,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [CHAN_W-1:0]         rsp_out_channel,
   input logic signed [SPEED_W-1:0] rsp_drive,
   input logic                      rsp_last
);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_tick_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_TICK) |=> req_stall)
      else $error("request taken while a tick scan runs");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_out_channel) < NUM_CHANNELS))
      else $error("response channel out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_channel) &&
                                    $stable(rsp_drive) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind multichannel_slew_limiter slr_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_slr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_channel (rsp_out_channel),
   .rsp_drive       (rsp_drive),
   .rsp_last        (rsp_last)
);

// File: bench/multichannel_slew_limiter_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// multichannel_slew_limiter_tb
// Self-checking bench for the per-channel ramp limiter. A scoreboard class
// keeps its own copy of every channel's target, Q8.8 ramp and slew and of
// the clamp bounds, predicts the drive updates of each tick and checks every
// accepted update in order. A directed opening covers the edge cases, then
// random requests run under several clamp settings with bursty requests,
// varied output stalls, two long output hold-offs and drains between phases.
// -----------------------------------------------------------------------------
module multichannel_slew_limiter_tb
   import slr_pkg::*;
();
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   localparam int NCH           = NUM_CHANNELS_DEF;
   localparam int SETTLE_CYCLES = NCH + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int NUM_PHASES    = 6;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0]         chan;
      logic signed [SPEED_W-1:0] drive;
      logic                      last;
   } drive_update_type;

   class ramp_scoreboard;
      logic signed [SPEED_W-1:0] target_spd [NUM_CHANNELS_DEF];
      logic signed [RAMP_W-1:0]  ramp_q88   [NUM_CHANNELS_DEF];
      logic        [SLEW_W-1:0]  slew_q88   [NUM_CHANNELS_DEF];
      bit                        active     [NUM_CHANNELS_DEF];
      logic signed [SPEED_W-1:0] limit_max;
      logic signed [SPEED_W-1:0] limit_min;
      drive_update_type          pending_drives [$];
      int                        tick_count;

      function new();
         for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
            target_spd[i] = '0;
            ramp_q88[i]   = '0;
            slew_q88[i]   = '0;
            active[i]     = 1'b0;
         end
         limit_max  = SPEED_MAX_RST;
         limit_min  = SPEED_MIN_RST;
         tick_count = 0;
      endfunction

      function void write_limit(logic [CSR_IDX_W-1:0] idx, logic [SPEED_W-1:0] data);
         if (idx == CSR_SPEED_MAX)
            limit_max = data;
         else if (idx == CSR_SPEED_MIN)
            limit_min = data;
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] chan,
                                 logic signed [SPEED_W-1:0] speed,
                                 logic [SLEW_W-1:0] slew);
         int               v;
         int               goal;
         int               step;
         int               hi;
         int               lo;
         int               mag;
         drive_update_type held;
         bit               have_held;
         if (kind == KIND_TICK) begin
            tick_count++;
            have_held = 1'b0;
            held      = '0;
            for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
               if (!active[i])
                  continue;
               v    = ramp_q88[i];
               goal = int'(target_spd[i]) * 256;
               step = int'(slew_q88[i]);
               if (v == goal)
                  continue;
               if (goal > v) begin
                  v = v + step;
                  if (v > goal)
                     v = goal;
               end
               if (goal < v) begin
                  v = v - step;
                  if (v < goal)
                     v = goal;
               end
               hi = int'(limit_max) * 256;
               lo = int'(limit_min) * 256;
               if (v > hi)
                  v = hi;
               if (v < lo)
                  v = lo;
               ramp_q88[i] = v[RAMP_W-1:0];
               mag = (v < 0) ? -v : v;
               mag = mag / 256;
               if (v < 0)
                  mag = -mag;
               // hold one update back until the next shows whether it is last
               if (have_held)
                  pending_drives.push_back(held);
               held.chan  = CHAN_W'(i);
               held.drive = SPEED_W'(mag);
               held.last  = 1'b0;
               have_held  = 1'b1;
            end
            if (have_held) begin
               held.last = 1'b1;
               pending_drives.push_back(held);
            end
            return;
         end
         if (chan >= NUM_CHANNELS_DEF)
            return;
         case (kind)
            KIND_SET_TARGET: begin
               target_spd[chan] = speed;
            end
            KIND_SET_BYPASS: begin
               target_spd[chan] = speed;
               ramp_q88[chan]   = {speed, {FRAC_W{1'b0}}};
            end
            KIND_SET_SLEW: begin
               slew_q88[chan] = slew;
            end
            KIND_ADD_CHANNEL: begin
               target_spd[chan] = '0;
               ramp_q88[chan]   = '0;
               slew_q88[chan]   = slew;
               active[chan]     = 1'b1;
            end
            KIND_ACTIVATE: begin
               active[chan] = 1'b1;
            end
            KIND_DEACTIVATE: begin
               active[chan] = 1'b0;
            end
            default: begin
            end
         endcase
      endfunction

      function bit check_result(logic [CHAN_W-1:0] chan, logic signed [SPEED_W-1:0] drive,
                                logic last, output string msg);
         drive_update_type want;
         if (pending_drives.size() == 0) begin
            msg = $sformatf("unexpected update: channel %0d drive %0d last %0b",
                            chan, drive, last);
            return 1'b0;
         end
         want = pending_drives.pop_front();
         msg  = "";
         if (chan !== want.chan)
            msg = {msg, $sformatf(" channel %0d/%0d", chan, want.chan)};
         if (drive !== want.drive)
            msg = {msg, $sformatf(" drive %0d/%0d", drive, want.drive)};
         if (last !== want.last)
            msg = {msg, $sformatf(" last %0b/%0b", last, want.last)};
         if (msg != "") begin
            msg = {"update mismatch (got/expected):", msg};
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function int pending();
         return pending_drives.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [KIND_W-1:0]         req_kind;
   logic [CHAN_W-1:0]         req_channel;
   logic signed [SPEED_W-1:0] req_speed;
   logic [SLEW_W-1:0]         req_slew_rate;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CHAN_W-1:0]         rsp_out_channel;
   logic signed [SPEED_W-1:0] rsp_drive;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [SPEED_W-1:0]        csr_wdata;

   ramp_scoreboard sb = new();

   int             errors         = 0;
   int             cycle_count    = 0;
   int             requests_seen  = 0;
   int             drives_checked = 0;
   int             csr_writes     = 0;
   int             hold_asked     = 0;
   int             hold_done      = 0;
   int             hold_left      = 0;
   stall_mode_type rsp_mode       = STALL_LIGHT;

   int             ph_max   [NUM_PHASES] = '{127, -20, 0, 0, -128, 50};
   int             ph_min   [NUM_PHASES] = '{-128, 30, 0, 0, 127, -50};
   int             ph_items [NUM_PHASES] = '{60, 40, 25, 44, 20, 55};
   stall_mode_type ph_mode  [NUM_PHASES] = '{STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC,
                                             STALL_NONE, STALL_LIGHT, STALL_HEAVY};
   bit             ph_hold  [NUM_PHASES] = '{0, 0, 0, 1, 0, 1};
   bit             ph_gaps  [NUM_PHASES] = '{1, 1, 1, 0, 1, 1};

   multichannel_slew_limiter #(
      .NUM_CHANNELS(NCH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_speed      (req_speed),
      .req_slew_rate  (req_slew_rate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_channel(rsp_out_channel),
      .rsp_drive      (rsp_drive),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task report(input string msg);
      errors++;
      $display("[cycle %0d] %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin
      string msg;
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            drives_checked++;
            if (!sb.check_result(rsp_out_channel, rsp_drive, rsp_last, msg))
               report(msg);
         end
         if (req_valid && !req_stall) begin
            requests_seen++;
            sb.note_request(req_kind, req_channel, req_speed, req_slew_rate);
         end
         if (csr_valid && csr_ready) begin
            csr_writes++;
            sb.write_limit(csr_index, csr_wdata);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_asked != hold_done) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (rsp_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            default:        rsp_stall <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d updates outstanding", cycle_count, sb.pending());
      $display("Verification failed");
      $finish;
   end

   task send_request(input logic [KIND_W-1:0] kind, input int chan, input int speed,
                     input int slew);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_channel   <= CHAN_W'(chan);
      req_speed     <= SPEED_W'(speed);
      req_slew_rate <= SLEW_W'(slew);
      do @(posedge clock); while (req_stall);
   endtask

   task pause_requests(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_limits(input int max_val, input int min_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_SPEED_MAX;
      csr_wdata <= SPEED_W'(max_val);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_SPEED_MIN;
      csr_wdata <= SPEED_W'(min_val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task random_request();
      int                pick;
      int                chan;
      int                slew;
      logic [KIND_W-1:0] kind;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         kind = KIND_TICK;
      else if (pick < 55)
         kind = KIND_SET_TARGET;
      else if (pick < 63)
         kind = KIND_SET_BYPASS;
      else if (pick < 72)
         kind = KIND_SET_SLEW;
      else if (pick < 82)
         kind = KIND_ADD_CHANNEL;
      else if (pick < 90)
         kind = KIND_ACTIVATE;
      else if (pick < 97)
         kind = KIND_DEACTIVATE;
      else
         kind = KIND_UNUSED;
      if ($urandom_range(0, 9) == 0)
         chan = $urandom_range(NCH, (1 << CHAN_W) - 1);
      else
         chan = $urandom_range(0, NCH - 1);
      case ($urandom_range(0, 3))
         0:       slew = $urandom_range(0, (1 << SLEW_W) - 1);
         1:       slew = $urandom_range(0, 600);
         2:       slew = $urandom_range(0, 4096);
         default: slew = 0;
      endcase
      send_request(kind, chan, $urandom_range(0, 255), slew);
   endtask

   initial begin
      int burst_left;
      int max_val;
      int min_val;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_SET_TARGET;
      req_channel   = '0;
      req_speed     = '0;
      req_slew_rate = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_SPEED_MAX;
      csr_wdata     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // tick with nothing active, then ramp and clamp at the default bounds
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_ADD_CHANNEL, 0, 0, 'h0100);
      send_request(KIND_SET_TARGET, 0, 127, 0);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_ADD_CHANNEL, 9, 0, (1 << SLEW_W) - 1);
      send_request(KIND_SET_TARGET, 9, -128, 0);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_SET_BYPASS, 1, -128, 0);
      send_request(KIND_ACTIVATE, 1, 0, 0);
      send_request(KIND_ADD_CHANNEL, 2, 0, 0);
      send_request(KIND_SET_TARGET, 2, 50, 0);
      send_request(KIND_SET_SLEW, 0, 0, 'h0080);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_SET_TARGET, 15, 100, 'h7F00);
      send_request(KIND_UNUSED, 3, 127, (1 << SLEW_W) - 1);
      send_request(KIND_ADD_CHANNEL, 10, 0, 'h0100);
      send_request(KIND_SET_BYPASS, 3, 127, 0);
      send_request(KIND_ACTIVATE, 3, 0, 0);
      send_request(KIND_SET_TARGET, 1, 127, 0);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_TICK, 0, 0, 0);
      send_request(KIND_DEACTIVATE, 0, 0, 0);
      send_request(KIND_DEACTIVATE, 1, 0, 0);
      send_request(KIND_DEACTIVATE, 2, 0, 0);
      send_request(KIND_DEACTIVATE, 9, 0, 0);
      send_request(KIND_TICK, 0, 0, 0);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         rsp_mode = ph_mode[p];
         max_val  = ph_max[p];
         min_val  = ph_min[p];
         if (p == 3) begin
            min_val = $urandom_range(0, 255) - 128;
            max_val = $urandom_range(min_val + 128, 255) - 128;
         end
         write_limits(max_val, min_val);
         burst_left = $urandom_range(1, 20);
         for (int n = 0; n < ph_items[p]; n++) begin
            if (ph_hold[p] && n == 8)
               hold_asked++;
            random_request();
            if (ph_gaps[p]) begin
               burst_left--;
               if (burst_left == 0) begin
                  pause_requests($urandom_range(1, 8));
                  burst_left = $urandom_range(1, 20);
               end
            end
         end
         wait_drained();
      end

      $display("Covered %0d requests including %0d ticks, %0d drive updates checked",
               requests_seen, sb.tick_count, drives_checked);
      $display("across %0d clamp settings with %0d register writes; %0d mismatches",
               NUM_PHASES + 1, csr_writes, errors);
      if (errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// File: sim.f
src/slr_pkg.sv
src/slr_mem.sv
src/slr_ramp.sv
src/multichannel_slew_limiter.sv
src/slr_checker.sv
bench/multichannel_slew_limiter_tb.sv
